// ----- rtl/escape_lz_window_decoder_top_macros.svh -----
// Assertion macros for the window decoder.
`ifndef ESCAPE_LZ_WINDOW_DECODER_TOP_MACROS_SVH
`define ESCAPE_LZ_WINDOW_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ELZ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ELZ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ELZ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ELZ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/elzwd_pkg.sv -----
package elzwd_pkg;
  localparam int unsigned HistoryDepth = 65536;
  localparam logic [22:0] BwMax = 23'h7FFFFF;

  typedef struct packed {
    logic       stream_end;
    logic [7:0] data_byte;
  } elzwd_in_t;

  typedef struct packed {
    logic [2:0]  error_code;
    logic        end_seen;
    logic        last_of_run;
    logic [3:0]  out_count;
    logic [63:0] out_bytes;
  } elzwd_out_t;

  localparam logic [2:0] ErrNone    = 3'd0;
  localparam logic [2:0] ErrBadCode = 3'd1;
  localparam logic [2:0] ErrFar     = 3'd2;
  localparam logic [2:0] ErrAfter   = 3'd3;
  localparam logic [2:0] ErrNoEnd   = 3'd4;

  localparam logic [1:0] CodeShort = 2'd0;
  localparam logic [1:0] CodeMid   = 2'd1;
  localparam logic [1:0] CodeLong  = 2'd2;
  localparam logic [1:0] CodeSpec  = 2'd3;

  localparam logic [7:0] SpecEscape = 8'd255;
  localparam logic [7:0] SpecEnd    = 8'd3;

  localparam logic [0:0] RegEscape = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_FLUSH,
    ST_OUT
  } elzwd_state_t;
endpackage

// ----- rtl/elzwd_ram.sv -----
module elzwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ----- rtl/escape_lz_window_decoder_top.sv -----
// A literal is written to history, then its result is flushed; a match of L bytes
// copies one byte at a time (history read, then write), results every 8 bytes.
// A new byte is taken only while idle, after the last byte and its result are done.
// A result waits in the output register; the decoder holds while it is not taken.
// rst_n (synchronous) clears all control state; history needs no clearing.
module escape_lz_window_decoder_top #(
  parameter int unsigned HISTORY_DEPTH = elzwd_pkg::HistoryDepth
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  elzwd_pkg::elzwd_in_t      in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output elzwd_pkg::elzwd_out_t     out_data,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [1:0]                cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);
  import elzwd_pkg::*;
  `include "escape_lz_window_decoder_top_macros.svh"

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  elzwd_state_t state_r, state_nxt;
  logic [7:0]  esc_r;
  logic        escaped_r, escaped_nxt;
  logic [31:0] code_r, code_nxt;
  logic [2:0]  held_r, held_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [22:0] bw_r, bw_nxt;
  logic        end_r, end_nxt;
  logic [63:0] buf_r, buf_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [8:0]  len_r, len_nxt;
  logic [22:0] dist_r, dist_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        flag_r, flag_nxt;   // a trailing empty result is due
  logic        ov_r, ov_nxt;
  elzwd_out_t  od_r, od_nxt;
  logic        fin_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;
  logic [23:0]   wp_ext, dist_ext, src_addr;

  // literal bytes come from the request and escape-255 bytes from the escape register, not the memory
  logic lit_r, lit_nxt;
  logic [7:0] litb_r, litb_nxt;
  logic [7:0] copy_byte;

  elzwd_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[1:0] == {RegEscape, 1'b0}) ? {24'd0, esc_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 8'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == {RegEscape, 1'b0}) begin
      esc_r <= cfg_pwdata[7:0];
    end
  end

  logic out_free;
  assign out_free = !ov_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = ov_r;
  assign out_data = od_r;

  logic        acc;
  logic [31:0] cw;
  logic [2:0]  hn;
  logic [2:0]  need;
  logic [22:0] dfull;
  logic [8:0]  lfull;
  logic [63:0] ins_buf;
  logic [3:0]  ins_cnt;

  // wrap the source address modulo the history depth
  assign wp_ext = 24'(wp_r);
  assign dist_ext = {1'b0, dist_r};
  assign src_addr = (wp_ext >= dist_ext) ? wp_ext - dist_ext
                                         : wp_ext + 24'(HISTORY_DEPTH) - dist_ext;
  assign raddr = src_addr[AW-1:0];

  assign copy_byte = lit_r ? litb_r : rdata;

  always_comb begin
    state_nxt = state_r;
    escaped_nxt = escaped_r;
    code_nxt = code_r;
    held_nxt = held_r;
    wp_nxt = wp_r;
    bw_nxt = bw_r;
    end_nxt = end_r;
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    len_nxt = len_r;
    dist_nxt = dist_r;
    err_nxt = err_r;
    flag_nxt = flag_r;
    ov_nxt = ov_r && out_stall;
    od_nxt = od_r;
    we = 1'b0;
    waddr = wp_r;
    wdata = copy_byte;
    acc = in_valid && (state_r == ST_IDLE);
    cw = code_r | ({24'd0, in_data.data_byte} << {held_r[1:0], 3'b000});
    hn = held_r + 3'd1;
    unique case (cw[1:0])
      CodeShort: need = 3'd2;
      CodeMid:   need = 3'd3;
      CodeLong:  need = 3'd4;
      default:   need = 3'd1;
    endcase
    unique case (cw[1:0])
      CodeShort: begin
        dfull = {13'd0, cw[11:2]} + 23'd4;
        lfull = {5'd0, cw[15:12]} + 9'd4;
      end
      CodeMid: begin
        dfull = {7'd0, cw[17:2]} + 23'd5;
        lfull = {3'd0, cw[23:18]} + 9'd5;
      end
      default: begin
        dfull = {1'b0, cw[23:2]} + 23'd6;
        lfull = {1'b0, cw[31:24]} + 9'd6;
      end
    endcase
    ins_buf = buf_r | ({56'd0, wdata} << {cnt_r[2:0], 3'b000});
    ins_cnt = cnt_r + 4'd1;
    fin_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          buf_nxt = 64'd0;
          cnt_nxt = 4'd0;
          len_nxt = 9'd0;
          err_nxt = ErrNone;
          flag_nxt = in_data.stream_end;
          state_nxt = ST_FLUSH;
          if (end_r) begin
            err_nxt = ErrAfter;
            flag_nxt = 1'b1;
          end else if (!escaped_r) begin
            if (in_data.data_byte == esc_r) begin
              escaped_nxt = 1'b1;
              code_nxt = 32'd0;
              held_nxt = 3'd0;
            end else begin
              len_nxt = 9'd1;
              dist_nxt = 23'd0;
              state_nxt = ST_COPY_WR;
            end
          end else begin
            code_nxt = cw;
            held_nxt = hn;
            if (hn >= need) begin
              escaped_nxt = 1'b0;
              code_nxt = 32'd0;
              held_nxt = 3'd0;
              if (cw[1:0] == CodeSpec) begin
                if (cw[7:0] == SpecEscape) begin
                  len_nxt = 9'd1;
                  dist_nxt = 23'd0;
                  state_nxt = ST_COPY_WR;
                end else if (cw[7:0] == SpecEnd) begin
                  end_nxt = 1'b1;
                  flag_nxt = 1'b1;
                end else begin
                  err_nxt = ErrBadCode;
                  flag_nxt = 1'b1;
                end
              end else if (dfull > bw_r || dfull > 23'(HISTORY_DEPTH)) begin
                err_nxt = ErrFar;
                flag_nxt = 1'b1;
              end else begin
                len_nxt = lfull;
                dist_nxt = dfull;
                state_nxt = ST_COPY_RD;
              end
            end
          end
          if (in_data.stream_end && !end_nxt && !end_r && err_nxt == ErrNone) begin
            err_nxt = ErrNoEnd;
          end
        end
      end
      ST_COPY_RD: begin
        // wait for the registered history read
        state_nxt = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        if (out_free || cnt_r != 4'd8) begin
          if (cnt_r == 4'd8) begin
            ov_nxt = 1'b1;
            od_nxt = '{error_code: ErrNone, end_seen: end_r, last_of_run: 1'b0,
                       out_count: 4'd8, out_bytes: buf_r};
            ins_buf = {56'd0, wdata};
            ins_cnt = 4'd1;
          end
          we = 1'b1;
          wp_nxt = (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + AW'(1);
          if (bw_r != BwMax) bw_nxt = bw_r + 23'd1;
          buf_nxt = ins_buf;
          cnt_nxt = ins_cnt;
          len_nxt = len_r - 9'd1;
          state_nxt = (len_r == 9'd1) ? ST_FLUSH : ST_COPY_RD;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          if (cnt_r != 4'd0 || flag_r || err_r != ErrNone) begin
            ov_nxt = 1'b1;
            fin_nxt = 1'b1;
            od_nxt = '{error_code: err_r, end_seen: end_r, last_of_run: 1'b1,
                       out_count: cnt_r, out_bytes: buf_r};
          end
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    lit_nxt = lit_r;
    litb_nxt = litb_r;
    if (acc) begin
      lit_nxt = (state_nxt == ST_COPY_WR);
      litb_nxt = (!escaped_r) ? in_data.data_byte : esc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      escaped_r <= 1'b0;
      code_r <= 32'd0;
      held_r <= 3'd0;
      wp_r <= '0;
      bw_r <= 23'd0;
      end_r <= 1'b0;
      ov_r <= 1'b0;
      cnt_r <= 4'd0;
      len_r <= 9'd0;
      err_r <= ErrNone;
      flag_r <= 1'b0;
      lit_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      escaped_r <= escaped_nxt;
      code_r <= code_nxt;
      held_r <= held_nxt;
      wp_r <= wp_nxt;
      bw_r <= bw_nxt;
      end_r <= end_nxt;
      ov_r <= ov_nxt;
      cnt_r <= cnt_nxt;
      len_r <= len_nxt;
      err_r <= err_nxt;
      flag_r <= flag_nxt;
      lit_r <= (state_r == ST_COPY_WR && state_nxt != ST_COPY_WR) ? 1'b0 : lit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    dist_r <= dist_nxt;
    od_r <= od_nxt;
    litb_r <= litb_nxt;
  end

  `ELZ_ASSERT_IMPL(a_stall_busy, clk, rst_n, state_r != ST_IDLE, in_stall)
  `ELZ_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= 4'd8)
  `ELZ_ASSERT_NEXT(a_fin_valid, clk, rst_n, fin_nxt, out_valid && out_data.last_of_run)
  `ELZ_ASSERT_IMPL(a_no_write_idle, clk, rst_n, state_r == ST_IDLE, !we)
endmodule
